FILE: src/analog_axis_filter_unit_defines.svh
// Assertion macros shared by the analog axis filter RTL.
// Depends on nothing; each user supplies clk_i and rst_ni in its own scope.
`ifndef ANALOG_AXIS_FILTER_UNIT_DEFINES_SVH
`define ANALOG_AXIS_FILTER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// Checks that a property holds at every clock edge outside reset.
`define AAF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checks that a condition never becomes true outside reset.
`define AAF_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define AAF_ASSERT(lbl, prop, msg)
`define AAF_NEVER(lbl, expr, msg)
`endif
`endif

FILE: src/aaf_pkg.sv
// Shared types, sizes and codes for the analog axis filter.
// Used by every module of the block except aaf_ram; depends on nothing.
package aaf_pkg;

  localparam int unsigned MAX_WINDOW = 64;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned WSIZE_W    = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  // Window address, fill count (must reach MAX_WINDOW itself) and sum widths.
  localparam int unsigned ADDR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CNT_W   = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SUM_W   = SAMPLE_W + $clog2(MAX_WINDOW);
  localparam int unsigned DCNT_W  = $clog2(SUM_W + 1);

  typedef enum logic [1:0] {
    MODE_DROP = 2'd0,
    MODE_PASS = 2'd1,
    MODE_AVG  = 2'd2,
    MODE_LAST = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE  = 3'd0,
    CFG_LOWER = 3'd1,
    CFG_UPPER = 3'd2,
    CFG_DEAD  = 3'd3,
    CFG_WSIZE = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COND,
    ST_SUM,
    ST_DIV,
    ST_EMIT
  } state_e;

  // Outcome of the deadzone and range stage for one sample.
  typedef struct packed {
    logic                       keep;
    logic signed [SAMPLE_W-1:0] value;
  } cond_res_t;

  // Window length actually used: zero counts as one, large values saturate.
  function automatic logic [CNT_W-1:0] eff_size(input logic [WSIZE_W-1:0] ws);
    int unsigned w;
    w = int'(ws);
    if (w == 0) begin
      w = 1;
    end
    if (w > MAX_WINDOW) begin
      w = MAX_WINDOW;
    end
    return CNT_W'(w);
  endfunction

endpackage

FILE: src/aaf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Holds the sample window of the analog axis filter; no dependencies.
module aaf_ram #(
  parameter int unsigned DW    = 16,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/aaf_cond.sv
// Deadzone and range conditioning with the three sticky zone flags.
// Depends on aaf_pkg for widths and the cond_res_t result type.
module aaf_cond import aaf_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       upd_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic signed [SAMPLE_W-1:0] lower_i,
  input  logic signed [SAMPLE_W-1:0] upper_i,
  input  logic        [SAMPLE_W-1:0] dead_zone_i,
  output cond_res_t                  res_o
);

  logic dz_q, dz_d, below_q, below_d, above_q, above_d;
  logic [SAMPLE_W:0] mag;
  logic dz_hit;
  logic keep;
  logic signed [SAMPLE_W-1:0] val;

  // Magnitude needs one extra bit so that the most negative sample fits.
  assign mag = sample_i[SAMPLE_W-1] ? ({1'b0, ~sample_i} + (SAMPLE_W+1)'(1))
                                    : {1'b0, sample_i};
  assign dz_hit = mag < {1'b0, dead_zone_i};

  always_comb begin
    dz_d    = dz_q;
    below_d = below_q;
    above_d = above_q;
    keep    = 1'b1;
    val     = sample_i;
    if (dz_hit) begin
      if (dz_q) begin
        keep = 1'b0;
      end else begin
        val  = '0;
        dz_d = 1'b1;
      end
    end else begin
      dz_d = 1'b0;
    end
    // A zeroed rest sample still passes through the range check.
    if (keep) begin
      if (val < lower_i) begin
        if (below_q) begin
          keep = 1'b0;
        end else begin
          val     = lower_i;
          below_d = 1'b1;
          above_d = 1'b0;
        end
      end else if (val > upper_i) begin
        if (above_q) begin
          keep = 1'b0;
        end else begin
          val     = upper_i;
          above_d = 1'b1;
          below_d = 1'b0;
        end
      end else begin
        below_d = 1'b0;
        above_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q    <= 1'b0;
      below_q <= 1'b0;
      above_q <= 1'b0;
    end else if (upd_i) begin
      dz_q    <= dz_d;
      below_q <= below_d;
      above_q <= above_d;
    end
  end

  assign res_o.keep  = keep;
  assign res_o.value = val;

endmodule

FILE: src/aaf_div.sv
// Serial restoring divider: signed window sum over unsigned window length.
// One quotient bit per cycle; depends on aaf_pkg for widths.
`include "analog_axis_filter_unit_defines.svh"
module aaf_div import aaf_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic signed [SUM_W-1:0]    dividend_i,
  input  logic        [CNT_W-1:0]    divisor_i,
  output logic                       done_o,
  output logic signed [SAMPLE_W-1:0] quotient_o
);

  logic              busy_q, busy_d, done_q, done_d, neg_q, neg_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  rem_q, rem_d, div_q, div_d;
  logic [CNT_W:0]    rem_sh, rem_sub;
  logic              fits;
  logic [SUM_W-1:0]  quo_signed;

  assign rem_sh  = {rem_q, quo_q[SUM_W-1]};
  assign fits    = rem_sh >= {1'b0, div_q};
  assign rem_sub = rem_sh - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      neg_d  = dividend_i[SUM_W-1];
      // Negating the most negative sum wraps onto its correct unsigned magnitude.
      quo_d  = dividend_i[SUM_W-1] ? SUM_W'(-dividend_i) : SUM_W'(dividend_i);
      rem_d  = '0;
      div_d  = divisor_i;
      cnt_d  = DCNT_W'(SUM_W);
    end else if (busy_q) begin
      quo_d = {quo_q[SUM_W-2:0], fits};
      rem_d = fits ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      cnt_d = cnt_q - DCNT_W'(1);
      if (cnt_q == DCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  // Truncation toward zero: divide magnitudes, then restore the sign.
  assign quo_signed = neg_q ? (~quo_q + SUM_W'(1)) : quo_q;
  assign quotient_o = quo_signed[SAMPLE_W-1:0];
  assign done_o     = done_q;

  `AAF_NEVER(a_div_restart, start_i && busy_q, "divider restarted while busy")
  `AAF_ASSERT(a_div_rem_bound, busy_q |-> (rem_q < div_q), "partial remainder out of range")
  `AAF_ASSERT(a_div_done_pulse, done_q |=> !done_q, "divider done held for two cycles")

endmodule

FILE: src/analog_axis_filter_unit.sv
// Analog axis filter: deadzone, one-shot clamp and windowed average or last sample, or raw pass.
// A sample that closes no window passes through ST_COND alone before the block is ready again.
// In last-sample and pass mode the result goes from ST_COND through ST_EMIT into the output register.
// A closing window in average mode goes on through the RAM sweep (ST_SUM) and the bit-serial
// divider (ST_DIV) before ST_EMIT; a full, stalled output holds ST_EMIT in every mode.
// Reset (rst_ni low, asynchronous) restores register defaults, empties the window, clears flags.
`include "analog_axis_filter_unit_defines.svh"
module analog_axis_filter_unit import aaf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input sample stream.
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [SAMPLE_W-1:0]   s_axis_tdata_i,   // [15:0] sample (signed)
  // Filtered value stream.
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [SAMPLE_W-1:0]   m_axis_tdata_o,   // [15:0] filtered_value (signed)
  // Register write port.
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Any write to a defined register also restarts the
  // window; a write to an undefined index is ignored altogether.
  // ---------------------------------------------------------------------------
  mode_e                      mode_q;
  logic signed [SAMPLE_W-1:0] lower_q, upper_q;
  logic        [SAMPLE_W-1:0] dead_q;
  logic        [WSIZE_W-1:0]  wsize_q;
  logic                       cfg_hit;

  always_comb begin
    unique case (cfg_idx_e'(cfg_idx_i))
      CFG_MODE, CFG_LOWER, CFG_UPPER, CFG_DEAD, CFG_WSIZE: cfg_hit = cfg_we_i;
      default:                                             cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_AVG;
      lower_q <= {1'b1, {(SAMPLE_W-1){1'b0}}};
      upper_q <= {1'b0, {(SAMPLE_W-1){1'b1}}};
      dead_q  <= '0;
      wsize_q <= WSIZE_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MODE:  mode_q  <= mode_e'(cfg_data_i[1:0]);
        CFG_LOWER: lower_q <= cfg_data_i[SAMPLE_W-1:0];
        CFG_UPPER: upper_q <= cfg_data_i[SAMPLE_W-1:0];
        CFG_DEAD:  dead_q  <= cfg_data_i[SAMPLE_W-1:0];
        CFG_WSIZE: wsize_q <= cfg_data_i[WSIZE_W-1:0];
        default:   ;
      endcase
    end
  end

  logic [CNT_W-1:0] eff_n;
  assign eff_n = eff_size(wsize_q);

  // ---------------------------------------------------------------------------
  // Control and datapath registers.
  // ---------------------------------------------------------------------------
  state_e                     state_q, state_d;
  logic signed [SAMPLE_W-1:0] samp_q, samp_d;
  logic signed [SAMPLE_W-1:0] res_q, res_d;
  logic        [CNT_W-1:0]    fill_q, fill_d;
  logic        [CNT_W-1:0]    rd_idx_q, rd_idx_d;
  logic                       rd_pend_q, rd_pend_d;
  logic signed [SUM_W-1:0]    acc_q, acc_d;
  logic                       out_vld_q, out_vld_d;
  logic        [SAMPLE_W-1:0] out_data_q, out_data_d;

  logic                       in_beat;
  logic                       windowed;
  cond_res_t                  cond;
  logic        [CNT_W-1:0]    fill_base, fill_inc;
  logic                       win_full;
  logic                       mem_we, mem_re;
  logic        [SAMPLE_W-1:0] mem_rdata;
  logic                       sweep_done;
  logic                       div_start, div_done;
  logic signed [SAMPLE_W-1:0] div_quot;
  logic                       out_free;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;
  assign windowed        = (mode_q == MODE_AVG) || (mode_q == MODE_LAST);

  // The window slot for this sample; the slot count always stays below the
  // window length, but a stale count is folded back to the first slot.
  assign fill_base = (fill_q >= eff_n) ? '0 : fill_q;
  assign fill_inc  = fill_base + CNT_W'(1);
  assign win_full  = (fill_inc == eff_n);

  // The sweep issues one read a cycle and accumulates each read's data once the registered RAM output holds it.
  assign sweep_done = (rd_idx_q == eff_n) && !rd_pend_q;
  assign out_free   = !out_vld_q || m_axis_tready_i;

  aaf_cond u_cond (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .upd_i       ((state_q == ST_COND) && windowed),
    .sample_i    (samp_q),
    .lower_i     (lower_q),
    .upper_i     (upper_q),
    .dead_zone_i (dead_q),
    .res_o       (cond)
  );

  // The closing sample is written on the edge that enters the sweep, so the
  // first read, even of that very slot, already sees it: no forwarding needed.
  assign mem_we = (state_q == ST_COND) && windowed && cond.keep;
  assign mem_re = (state_q == ST_SUM) && (rd_idx_q != eff_n);

  aaf_ram #(
    .DW    (SAMPLE_W),
    .DEPTH (MAX_WINDOW),
    .AW    (ADDR_W)
  ) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (fill_base[ADDR_W-1:0]),
    .wdata_i (cond.value),
    .re_i    (mem_re),
    .raddr_i (rd_idx_q[ADDR_W-1:0]),
    .rdata_o (mem_rdata)
  );

  assign div_start = (state_q == ST_SUM) && sweep_done;

  aaf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_q),
    .divisor_i  (eff_n),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // ---------------------------------------------------------------------------
  // Next state.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          state_d = ST_COND;
        end
      end
      ST_COND: begin
        unique case (mode_q)
          MODE_DROP: state_d = ST_IDLE;
          MODE_PASS: state_d = ST_EMIT;
          MODE_AVG:  state_d = (cond.keep && win_full) ? ST_SUM : ST_IDLE;
          MODE_LAST: state_d = (cond.keep && win_full) ? ST_EMIT : ST_IDLE;
          default:   state_d = ST_IDLE;
        endcase
      end
      ST_SUM: begin
        if (sweep_done) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and output register.
  // ---------------------------------------------------------------------------
  always_comb begin
    samp_d     = samp_q;
    res_d      = res_q;
    fill_d     = fill_q;
    rd_idx_d   = rd_idx_q;
    rd_pend_d  = 1'b0;
    acc_d      = acc_q;
    out_vld_d  = out_vld_q && !m_axis_tready_i;
    out_data_d = out_data_q;

    if (in_beat) begin
      samp_d = s_axis_tdata_i;
    end

    unique case (state_q)
      ST_COND: begin
        if (mode_q == MODE_PASS) begin
          res_d = samp_q;
        end else if (windowed && cond.keep) begin
          fill_d   = win_full ? '0 : fill_inc;
          res_d    = cond.value;
          rd_idx_d = '0;
          acc_d    = '0;
        end
      end
      ST_SUM: begin
        rd_pend_d = mem_re;
        if (mem_re) begin
          rd_idx_d = rd_idx_q + CNT_W'(1);
        end
        if (rd_pend_q) begin
          acc_d = acc_q + SUM_W'(signed'(mem_rdata));
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_d = div_quot;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_data_d = res_q;
        end
      end
      default: ;
    endcase

    // Register writes must arrive only while the block is idle; the block itself does not enforce this.
    if (cfg_hit) begin
      fill_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      rd_idx_q  <= '0;
      rd_pend_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      rd_idx_q  <= rd_idx_d;
      rd_pend_q <= rd_pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    samp_q     <= samp_d;
    res_q      <= res_d;
    acc_q      <= acc_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

  `AAF_ASSERT(a_fill_bound, fill_q < eff_n, "window fill count reached the window length")
  `AAF_ASSERT(a_emit_loads, ((state_q == ST_EMIT) && !out_vld_q) |=> out_vld_q, "emit did not load output")
  `AAF_ASSERT(a_div_in_div, div_done |-> (state_q == ST_DIV), "divider finished outside its state")

endmodule
